// ----- rtl/core/day_number_to_civil_date_macros.svh -----
// Assertion macros shared by the day number to civil date core.
`ifndef DAY_NUMBER_TO_CIVIL_DATE_MACROS_SVH
`define DAY_NUMBER_TO_CIVIL_DATE_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define DNCD_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define DNCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/dncd_pkg.sv -----
// Constants, month table and weekday helpers for the day number to civil date core.
package dncd_pkg;

  localparam int unsigned DaysPer400Y     = 146097;
  localparam int unsigned DaysPer4Y       = 1461;
  localparam int unsigned LeapYearLimit   = 96;
  localparam int unsigned YearsPerCentury = 100;

  // Whole centuries added so that the scaled day count is never negative
  localparam int unsigned CycleBias = 65536;

  // Bias added to 4*n: cycle bias in quarter days, minus one
  localparam logic [34:0] ScaledBias =
    35'(64'(CycleBias) * 64'(DaysPer400Y) - 64'd1);

  // Reciprocal of the cycle length for the top 18 bits of the dividend (rounded down)
  localparam logic [31:0] Recip400Y = 32'((64'd1 << 49) / 64'(DaysPer400Y));

  // Reciprocal of the four-year length, rounded up, exact for 18-bit dividends
  localparam logic [18:0] Recip4Y =
    19'(((64'd1 << 29) + 64'(DaysPer4Y) - 64'd1) / 64'(DaysPer4Y));

  // Day of year at which each month starts, common year
  localparam logic [8:0] MonthStart [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // Sum the octal digits of a word: congruent to the word modulo 7
  function automatic logic [6:0] octal_digit_sum(input logic [31:0] u);
    logic [6:0] s;
    s = 7'(u[31:30]);
    for (int i = 0; i < 10; i++) begin
      s = s + 7'(u[3*i +: 3]);
    end
    return s;
  endfunction

  // Zero-based ISO weekday of (n - 1) from the digit sum of n and its sign
  function automatic logic [2:0] weekday_index(input logic [6:0] ds, input logic neg);
    logic [3:0] f1;
    logic [3:0] f2;
    logic [2:0] x;
    logic [3:0] t;
    f1 = 4'(ds[6]) + 4'(ds[5:3]) + 4'(ds[2:0]);
    f2 = 4'(f1[3]) + 4'(f1[2:0]);
    x  = (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];
    // minus one is plus six; the sign weight of -2^32 is plus three
    t  = 4'(x) + 4'd6 + (neg ? 4'd3 : 4'd0);
    if (t >= 4'd14) begin
      t = t - 4'd14;
    end else if (t >= 4'd7) begin
      t = t - 4'd7;
    end
    return t[2:0];
  endfunction

endpackage

// ----- rtl/core/day_number_to_civil_date.sv -----
// Pipelined conversion of a signed day number into a proleptic Gregorian civil date.
//
//   channel | signals                               | direction | word
//   --------+---------------------------------------+-----------+-------------------------
//   in      | in_valid_i, in_ready_o, day_number_i  | to core   | one day number
//   out     | out_valid_o, out_ready_i, *_o fields  | from core | one date, valid_res flag
//
// Eight register stages; one word can enter every clock cycle while the output is not
// stalled. Depth is set by the two reciprocal divisions (centuries, then four years):
// multiply, subtract and correct for the first, multiply and subtract for the second.
// Every stage holds a valid bit and loads whenever it is empty or its successor moves,
// so bubbles close up and a stalled output does not lose or repeat a word.
// Reset clears all valid bits; the payload registers are not reset.

`include "day_number_to_civil_date_macros.svh"

module day_number_to_civil_date
  import dncd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] day_number_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               valid_res_o,
  output logic signed [15:0] year_o,
  output logic [3:0]         month_o,
  output logic [4:0]         day_of_month_o,
  output logic [8:0]         day_of_year_o,
  output logic [2:0]         weekday_o,
  output logic               leap_year_o
);

  localparam logic [17:0] Cyc   = 18'(DaysPer400Y);
  localparam logic [18:0] Cyc2  = 19'(2 * DaysPer400Y);
  localparam logic [18:0] Cyc3  = 19'(3 * DaysPer400Y);
  localparam logic [10:0] Quad  = 11'(DaysPer4Y);
  localparam logic [6:0]  Cent  = 7'(YearsPerCentury);
  localparam logic [7:0]  LeapLim = 8'(LeapYearLimit);

  // Stage valid bits and load enables
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;
  logic en1, en2, en3, en4, en5, en6, en7, en8;

  // Stage payloads
  logic [34:0]        m1_q, m2_q, m3_q;
  logic [6:0]         ds1_q;
  logic               neg1_q;
  logic [16:0]        q2_q, q3_q, q4_q;
  logic [2:0]         wd2_q, wd3_q, wd4_q, wd5_q, wd6_q, wd7_q;
  logic [34:0]        p3_q;
  logic [18:0]        r4_q;
  logic [17:0]        sday5_q;
  logic signed [16:0] qc5_q;
  logic [17:0]        s6_q;
  logic [6:0]         qy6_q;
  logic [1:0]         qcl6_q;
  logic signed [23:0] yc6_q;
  logic [8:0]         doy7_q;
  logic               leap7_q;
  logic signed [23:0] year7_q;

  // Output register
  logic               valid_res_q;
  logic signed [15:0] year_q;
  logic [3:0]         month_q;
  logic [4:0]         dom_q;
  logic [8:0]         doy_q;
  logic [2:0]         wd_q;
  logic               leap_q;

  // Next values
  logic [34:0]        sx_d;
  logic [34:0]        m1_d;
  logic [49:0]        qprod_d;
  logic [34:0]        p3_d;
  logic [34:0]        diff_d;
  logic [17:0]        qn_d;
  logic [17:0]        sday5_d;
  logic [16:0]        qc5_d;
  logic [17:0]        s6_d;
  logic [36:0]        yprod_d;
  logic [17:0]        rem7_d;
  logic               leap7_d;
  logic signed [23:0] year7_d;
  logic               ok8_d;
  logic [3:0]         mon_d;
  logic [8:0]         adj_d;
  logic [8:0]         start_d;
  logic [4:0]         dom_d;

  // Advance a stage when it is empty or the next one takes its word
  assign en8 = !v8_q || out_ready_i;
  assign en7 = !v7_q || en8;
  assign en6 = !v6_q || en7;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o  = en1;
  assign out_valid_o = v8_q;

  // Stage 1: scale to quarter days and bias into the positive range
  assign sx_d = 35'(day_number_i);
  assign m1_d = {sx_d[32:0], 2'b00} + ScaledBias;

  // Stage 2: estimate the cycle count from the top bits, at most two low
  assign qprod_d = 50'(m1_q[34:17]) * 50'(Recip400Y);

  // Stage 3: product of estimate and cycle length
  assign p3_d = 35'(q2_q) * 35'(Cyc);

  // Stage 4: remainder of the estimate, below three centuries in quarter days
  assign diff_d = m3_q - p3_q;

  // Stage 5: correct the estimate and remove the bias
  always_comb begin
    if (r4_q >= Cyc2) begin
      sday5_d = 18'(r4_q - Cyc2);
      qn_d    = 18'(q4_q) + 18'd2;
    end else if (r4_q >= 19'(Cyc)) begin
      sday5_d = 18'(r4_q - 19'(Cyc));
      qn_d    = 18'(q4_q) + 18'd1;
    end else begin
      sday5_d = r4_q[17:0];
      qn_d    = 18'(q4_q);
    end
    qc5_d = 17'(qn_d - 18'(CycleBias));
  end

  // Stage 6: years within the century by reciprocal multiply
  assign s6_d    = sday5_q | 18'd3;
  assign yprod_d = 37'(s6_d) * 37'(Recip4Y);

  // Stage 7: day of year, leap flag and full year
  assign rem7_d  = s6_q - 18'(qy6_q * 18'(Quad));
  assign leap7_d = (qy6_q[1:0] == 2'b11) && (8'(qy6_q) <= LeapLim + 8'(qcl6_q));
  assign year7_d = yc6_q + 24'(qy6_q) + 24'sd1;

  // Stage 8: range check and month search over the start table
  always_comb begin
    ok8_d = (year7_q[23:15] == '0) || (year7_q[23:15] == '1);
    mon_d = 4'd0;
    for (int j = 0; j < 12; j++) begin
      adj_d = MonthStart[j] + ((leap7_q && j >= 2) ? 9'd1 : 9'd0);
      if (adj_d <= doy7_q) begin
        mon_d = 4'(j);
      end
    end
    start_d = MonthStart[mon_d] + ((leap7_q && mon_d >= 4'd2) ? 9'd1 : 9'd0);
    dom_d   = 5'(doy7_q - start_d + 9'd1);
  end

  // Move valid bits down the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
      if (en7) v7_q <= v6_q;
      if (en8) v8_q <= v7_q;
    end
  end

  // Load stage payloads, hold them while stalled
  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      m1_q   <= m1_d;
      ds1_q  <= octal_digit_sum(day_number_i);
      neg1_q <= day_number_i[31];
    end
    if (en2 && v1_q) begin
      m2_q  <= m1_q;
      q2_q  <= qprod_d[48:32];
      wd2_q <= weekday_index(ds1_q, neg1_q);
    end
    if (en3 && v2_q) begin
      m3_q  <= m2_q;
      q3_q  <= q2_q;
      p3_q  <= p3_d;
      wd3_q <= wd2_q;
    end
    if (en4 && v3_q) begin
      r4_q  <= diff_d[18:0];
      q4_q  <= q3_q;
      wd4_q <= wd3_q;
    end
    if (en5 && v4_q) begin
      sday5_q <= sday5_d;
      qc5_q   <= qc5_d;
      wd5_q   <= wd4_q;
    end
    if (en6 && v5_q) begin
      s6_q   <= s6_d;
      qy6_q  <= yprod_d[35:29];
      qcl6_q <= qc5_q[1:0];
      yc6_q  <= 24'(qc5_q) * 24'(Cent);
      wd6_q  <= wd5_q;
    end
    if (en7 && v6_q) begin
      doy7_q  <= rem7_d[10:2];
      leap7_q <= leap7_d;
      year7_q <= year7_d;
      wd7_q   <= wd6_q;
    end
    if (en8 && v7_q) begin
      valid_res_q <= ok8_d;
      year_q      <= ok8_d ? year7_q[15:0] : 16'sd0;
      month_q     <= ok8_d ? mon_d + 4'd1 : 4'd0;
      dom_q       <= ok8_d ? dom_d : 5'd0;
      doy_q       <= ok8_d ? doy7_q + 9'd1 : 9'd0;
      wd_q        <= ok8_d ? wd7_q + 3'd1 : 3'd0;
      leap_q      <= ok8_d && leap7_q;
    end
  end

  assign valid_res_o    = valid_res_q;
  assign year_o         = year_q;
  assign month_o        = month_q;
  assign day_of_month_o = dom_q;
  assign day_of_year_o  = doy_q;
  assign weekday_o      = wd_q;
  assign leap_year_o    = leap_q;

  // Reciprocal estimate must leave a remainder below three centuries in quarter days
  `DNCD_ASSERT(a_rem_range, v4_q, r4_q < Cyc3, "cycle estimate off by more than two")
  // Corrected remainder lies within one century
  `DNCD_ASSERT(a_cycle_rem, v5_q, sday5_q < Cyc, "cycle remainder not reduced")
  // An empty output never blocks the input
  `DNCD_ASSERT(a_ready_free, !v8_q, in_ready_o, "input stalled with empty output")
  // An accepted word occupies the first stage
  `DNCD_ASSERT_NEXT(a_enter, in_valid_i && in_ready_o, v1_q, "accepted word dropped")

endmodule

// ----- bench/day_number_to_civil_date_tb.sv -----
// Self-checking bench for the day number to civil date pipeline, with random idling.
module day_number_to_civil_date_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Calendar constants for the predictor
  localparam longint CycleDays    = 146097;
  localparam longint QuadYearDays = 1461;
  localparam longint LeapLimit    = 96;
  localparam longint CenturyYears = 100;
  localparam longint YearMin      = -32768;
  localparam longint YearMax      = 32767;
  localparam int     DrainCycles  = 20;
  localparam int     HoldCycles   = 80;
  localparam int     HoldAfter    = 300;
  localparam int     RandomDays   = 1080;

  localparam int unsigned MonthFirstDay [12] = '{
    0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
  };

  typedef struct packed {
    logic               valid_res;
    logic signed [15:0] year;
    logic [3:0]         month;
    logic [4:0]         day_of_month;
    logic [8:0]         day_of_year;
    logic [2:0]         weekday;
    logic               leap_year;
  } civil_date_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] day_number_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic               valid_res_o;
  logic signed [15:0] year_o;
  logic [3:0]         month_o;
  logic [4:0]         day_of_month_o;
  logic [8:0]         day_of_year_o;
  logic [2:0]         weekday_o;
  logic               leap_year_o;

  logic signed [31:0] pending_days [$];
  civil_date_t        expected_dates [$];
  int                 mismatch_count = 0;
  int                 dates_checked  = 0;
  int                 days_sent      = 0;
  int                 send_gap       = 0;
  int                 recv_wait      = 0;
  int                 hold_left      = 0;
  logic               hold_done      = 1'b0;

  day_number_to_civil_date dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .day_number_i   (day_number_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .valid_res_o    (valid_res_o),
    .year_o         (year_o),
    .month_o        (month_o),
    .day_of_month_o (day_of_month_o),
    .day_of_year_o  (day_of_year_o),
    .weekday_o      (weekday_o),
    .leap_year_o    (leap_year_o)
  );

  // Floor division for signed operands
  function automatic longint floor_div(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b != 0) && ((a < 0) != (b < 0))) begin
      q = q - 1;
    end
    return q;
  endfunction

  // Day number of January 1 of a given year
  function automatic longint new_year_day(input longint y);
    longint p;
    p = y - 1;
    return 365 * p + floor_div(p, 4) - floor_div(p, 100) + floor_div(p, 400) + 1;
  endfunction

  // Convert a day number into the civil date the block should return
  function automatic civil_date_t to_civil_date(input logic signed [31:0] dn);
    longint      days;
    longint      quarter;
    longint      cyc;
    longint      rest;
    longint      yr_in_cyc;
    longint      yr;
    longint      wd;
    logic        leap;
    int unsigned doy0;
    int unsigned first;
    int unsigned mon;
    civil_date_t d;
    days    = dn;
    quarter = days * 4 - 1;
    if (quarter >= 0) begin
      cyc = quarter / CycleDays;
    end else begin
      cyc = -((-quarter + CycleDays - 1) / CycleDays);
    end
    // Force the low bits so the four-year division lands on the right year
    rest      = (quarter - cyc * CycleDays) | 64'sd3;
    yr_in_cyc = rest / QuadYearDays;
    rest      = rest - yr_in_cyc * QuadYearDays;
    leap      = ((yr_in_cyc & 3) == 3) && (yr_in_cyc <= LeapLimit + (cyc & 3));
    yr        = cyc * CenturyYears + yr_in_cyc + 1;
    d = '0;
    if (yr < YearMin || yr > YearMax) begin
      return d;
    end
    doy0 = int'(rest >>> 2);
    mon  = 0;
    for (int m = 0; m < 12; m++) begin
      if (MonthFirstDay[m] + ((leap && m >= 2) ? 1 : 0) <= doy0) begin
        mon = m;
      end
    end
    first = MonthFirstDay[mon] + ((leap && mon >= 2) ? 1 : 0);
    wd = (days - 1) % 7;
    if (wd < 0) begin
      wd = wd + 7;
    end
    d.valid_res    = 1'b1;
    d.year         = 16'(yr);
    d.month        = 4'(mon + 1);
    d.day_of_month = 5'(doy0 - first + 1);
    d.day_of_year  = 9'(doy0 + 1);
    d.weekday      = 3'(wd + 1);
    d.leap_year    = leap;
    return d;
  endfunction

  // Print one line per mismatch and count it
  task automatic flag_mismatch(input string what);
    $display("%0t ERROR %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic compare_field(input string field, input int unsigned got,
                               input int unsigned want);
    if (got != want) begin
      flag_mismatch($sformatf("%s: got %0d, expected %0d", field, got, want));
    end
  endtask

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sender: present the next day number, then idle for a drawn gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      day_number_i <= '0;
      send_gap     <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap   <= send_gap - 1;
      end else if (pending_days.size() > 0) begin
        in_valid_i   <= 1'b1;
        day_number_i <= pending_days.pop_front();
        days_sent    <= days_sent + 1;
        // every third stretch of words goes back to back
        send_gap     <= ((days_sent / 128) % 3 == 0) ? 0 : $urandom_range(0, 5);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Long hold-off on the result side, once, so the pipeline backs up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && dates_checked >= HoldAfter) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: stall for a drawn number of cycles after each word, except in back-to-back stretches
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_wait   <= 0;
    end else if (hold_left > 0) begin
      out_ready_i <= 1'b0;
    end else if (out_ready_i && out_valid_o) begin
      // every fourth stretch of dates is taken back to back
      recv_wait   <= ((dates_checked / 150) % 4 == 1) ? 0 : $urandom_range(0, 5);
      out_ready_i <= ((dates_checked / 150) % 4 == 1);
    end else if (!out_ready_i) begin
      if (recv_wait == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        recv_wait <= recv_wait - 1;
      end
    end
  end

  // Check each date leaving the block, then record what entered it
  always @(posedge clk_i) begin
    civil_date_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_dates.size() == 0) begin
          flag_mismatch("date word with nothing expected");
        end else begin
          want = expected_dates.pop_front();
          compare_field("valid_res", valid_res_o, want.valid_res);
          compare_field("year", 16'(year_o), 16'(want.year));
          compare_field("month", month_o, want.month);
          compare_field("day_of_month", day_of_month_o, want.day_of_month);
          compare_field("day_of_year", day_of_year_o, want.day_of_year);
          compare_field("weekday", weekday_o, want.weekday);
          compare_field("leap_year", leap_year_o, want.leap_year);
        end
        dates_checked <= dates_checked + 1;
      end
      if (in_valid_i && in_ready_o) begin
        expected_dates.push_back(to_civil_date(day_number_i));
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    longint lo;
    longint hi;
    longint y;
    int     sel;
    lo = new_year_day(YearMin);
    hi = new_year_day(YearMax + 1) - 1;
    // Directed: field extremes, epoch, year range edges, leap and century days
    pending_days.push_back(32'sd1);
    pending_days.push_back(32'sd0);
    pending_days.push_back(-32'sd1);
    pending_days.push_back(32'sh7fff_ffff);
    pending_days.push_back(32'sh8000_0000);
    pending_days.push_back(32'(lo));
    pending_days.push_back(32'(lo - 1));
    pending_days.push_back(32'(hi));
    pending_days.push_back(32'(hi + 1));
    pending_days.push_back(32'(new_year_day(YearMax)));
    pending_days.push_back(32'(new_year_day(2000) + 59));
    pending_days.push_back(32'(new_year_day(2001) - 1));
    pending_days.push_back(32'(new_year_day(1900) + 58));
    pending_days.push_back(32'(new_year_day(1900) + 59));
    pending_days.push_back(32'(new_year_day(1901) - 1));
    pending_days.push_back(32'(new_year_day(0) - 1));
    pending_days.push_back(32'(new_year_day(-4) + 59));
    pending_days.push_back(32'(new_year_day(-100) + 59));
    pending_days.push_back(32'(new_year_day(1970)));
    pending_days.push_back(32'(new_year_day(2024) + 365));
    // Random: mostly in-range dates, with year edges, small values and raw words
    for (int i = 0; i < RandomDays; i++) begin
      sel = $urandom_range(0, 19);
      if (sel < 3) begin
        pending_days.push_back($urandom);
      end else if (sel < 6) begin
        y = longint'($urandom_range(0, 65539)) - 32770;
        pending_days.push_back(32'(new_year_day(y) + $urandom_range(0, 4) - 2));
      end else if (sel < 8) begin
        pending_days.push_back(32'(longint'($urandom_range(0, 2000)) - 1000));
      end else begin
        pending_days.push_back(32'(lo + longint'($urandom_range(0, 32'(hi - lo)))));
      end
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Wait until every word has gone in and every date has come out
    while (pending_days.size() != 0 || in_valid_i || expected_dates.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("day_number_to_civil_date: match");
    end else begin
      $display("day_number_to_civil_date: mismatch");
    end
    $finish;
  end

  // Timeout
  initial begin
    #2ms;
    $display("day_number_to_civil_date: mismatch");
    $finish;
  end

endmodule
